// ===== hw/rtl/snt_pkg.sv =====
// Shared codes and types for the sorted neighbor table.
// Used by snt_engine and sorted_neighbor_table; depends on nothing.
`default_nettype none
package snt_pkg;

  localparam logic [1:0] FN_SENDER = 2'd0;
  localparam logic [1:0] FN_FAR    = 2'd1;
  localparam logic [1:0] FN_AGE    = 2'd2;

  localparam logic [3:0] ST_UPDATED   = 4'd0;
  localparam logic [3:0] ST_INSERTED  = 4'd1;
  localparam logic [3:0] ST_FULL      = 4'd2;
  localparam logic [3:0] ST_OWN       = 4'd3;
  localparam logic [3:0] ST_DIRECT    = 4'd4;
  localparam logic [3:0] ST_KNOWN     = 4'd5;
  localparam logic [3:0] ST_FAR_ADDED = 4'd6;
  localparam logic [3:0] ST_FAR_FULL  = 4'd7;
  localparam logic [3:0] ST_REMOVED   = 4'd8;
  localparam logic [3:0] ST_NONE      = 4'd9;

  localparam logic CFG_OWN_ID    = 1'b0;
  localparam logic CFG_STALE_GAP = 1'b1;

  typedef enum logic [3:0] {
    ES_IDLE,
    ES_SRCH_CHK,
    ES_SRCH_CMP,
    ES_AGE_CHK,
    ES_AGE_CMP,
    ES_SHIFT_CHK,
    ES_SHIFT_WR,
    ES_NEW_WR,
    ES_DONE
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] peer_id;
    logic [15:0] seq_value;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] position;
    logic [5:0] neighbor_total;
    logic [8:0] two_hop_total;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/snt_engine.sv =====
// Table sequencer: direct and two-hop memories, binary search, scan and shift.
// Depends on snt_pkg.
`default_nettype none
module snt_engine #(
  parameter int DIRECT_DEPTH = 32,
  parameter int FAR_DEPTH    = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  snt_pkg::req_t req,
  input  logic [15:0]   own_id,
  input  logic [15:0]   stale_gap,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ack,
  output snt_pkg::res_t res
);
  import snt_pkg::*;

  localparam int DCW = $clog2(DIRECT_DEPTH + 1);
  localparam int FCW = $clog2(FAR_DEPTH + 1);
  localparam int DAW = $clog2(DIRECT_DEPTH);
  localparam int FAW = $clog2(FAR_DEPTH);
  localparam int SW  = (DCW > FCW) ? DCW : FCW;

  eng_state_t state, state_next;

  logic [1:0]    func_r, func_r_next;
  logic [15:0]   key, key_next;
  logic [15:0]   seq_r, seq_r_next;
  logic [SW-1:0] lo, lo_next, hi, hi_next;
  logic [SW-1:0] cur, cur_next, at, at_next;
  logic [SW-1:0] pos_r, pos_r_next;
  logic [3:0]    status_r, status_r_next;
  logic          far_phase, far_phase_next;
  logic          up, up_next;
  logic [DCW-1:0] dcount, dcount_next;
  logic [FCW-1:0] fcount, fcount_next;

  logic [15:0] d_ids [DIRECT_DEPTH];
  logic [15:0] d_seqs [DIRECT_DEPTH];
  logic [15:0] f_ids [FAR_DEPTH];
  logic [15:0] d_rid, d_rseq, f_rdata;

  logic [SW-1:0] raddr, waddr;
  logic          d_we, f_we;
  logic [15:0]   d_wid, d_wseq, f_wdata;

  logic [SW:0]   mid_sum, cur_inc;
  logic [SW-1:0] mid, srch_pos;
  logic [15:0]   op_a, op_b, absd;
  logic [16:0]   diff;
  logic          eq, a_lt, stale;
  logic          srch_more, srch_end, srch_found, shift_more, age_more;
  logic          d_full, f_full;

  // shared compare / subtract unit
  assign op_a  = (state == ES_AGE_CMP) ? d_rseq : (far_phase ? f_rdata : d_rid);
  assign op_b  = (state == ES_AGE_CMP) ? seq_r : key;
  assign diff  = {1'b0, op_a} - {1'b0, op_b};
  assign eq    = (diff == 17'd0);
  assign a_lt  = diff[16];
  assign absd  = a_lt ? ((~diff[15:0]) + 16'd1) : diff[15:0];
  assign stale = (absd > stale_gap);

  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[SW:1];
  assign cur_inc    = {1'b0, cur} + {{SW{1'b0}}, 1'b1};
  assign srch_more  = (lo < hi);
  assign srch_end   = ((state == ES_SRCH_CHK) && !srch_more) || ((state == ES_SRCH_CMP) && eq);
  assign srch_found = (state == ES_SRCH_CMP);
  assign srch_pos   = srch_found ? mid : lo;
  assign shift_more = up ? (cur > at) : (cur_inc < (SW + 1)'(dcount));
  assign age_more   = (cur < SW'(dcount));
  assign d_full     = (dcount >= DCW'(DIRECT_DEPTH));
  assign f_full     = (fcount >= FCW'(FAR_DEPTH));

  always_comb begin
    case (state)
      ES_SRCH_CHK:  raddr = mid;
      ES_SHIFT_CHK: raddr = up ? (cur - SW'(1)) : cur_inc[SW-1:0];
      ES_AGE_CHK:   raddr = cur;
      default:      raddr = mid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      d_ids[waddr[DAW-1:0]]  <= d_wid;
      d_seqs[waddr[DAW-1:0]] <= d_wseq;
    end
    d_rid  <= d_ids[raddr[DAW-1:0]];
    d_rseq <= d_seqs[raddr[DAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      f_ids[waddr[FAW-1:0]] <= f_wdata;
    end
    f_rdata <= f_ids[raddr[FAW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      ES_IDLE: begin
        if (start) begin
          case (req.func)
            FN_SENDER: state_next = ES_SRCH_CHK;
            FN_FAR:    state_next = ((req.peer_id == own_id) || f_full) ? ES_DONE : ES_SRCH_CHK;
            FN_AGE:    state_next = ES_AGE_CHK;
            default:   state_next = ES_DONE;
          endcase
        end
      end
      ES_SRCH_CHK, ES_SRCH_CMP: begin
        if (srch_end) begin
          if (srch_found) begin
            state_next = ES_DONE;
          end else if (far_phase) begin
            state_next = ES_SHIFT_CHK;
          end else if (func_r == FN_SENDER) begin
            state_next = d_full ? ES_DONE : ES_SHIFT_CHK;
          end else begin
            state_next = ES_SRCH_CHK;
          end
        end else if (state == ES_SRCH_CHK) begin
          state_next = ES_SRCH_CMP;
        end else begin
          state_next = ES_SRCH_CHK;
        end
      end
      ES_AGE_CHK:   state_next = age_more ? ES_AGE_CMP : ES_DONE;
      ES_AGE_CMP:   state_next = stale ? ES_SHIFT_CHK : ES_AGE_CHK;
      ES_SHIFT_CHK: state_next = shift_more ? ES_SHIFT_WR : (up ? ES_NEW_WR : ES_DONE);
      ES_SHIFT_WR:  state_next = ES_SHIFT_CHK;
      ES_NEW_WR:    state_next = ES_DONE;
      ES_DONE:      state_next = res_ack ? ES_IDLE : ES_DONE;
      default:      state_next = ES_IDLE;
    endcase
  end

  always_comb begin
    func_r_next    = func_r;
    key_next       = key;
    seq_r_next     = seq_r;
    lo_next        = lo;
    hi_next        = hi;
    cur_next       = cur;
    at_next        = at;
    pos_r_next     = pos_r;
    status_r_next  = status_r;
    far_phase_next = far_phase;
    up_next        = up;
    dcount_next    = dcount;
    fcount_next    = fcount;
    d_we           = 1'b0;
    f_we           = 1'b0;
    waddr          = cur;
    d_wid          = d_rid;
    d_wseq         = d_rseq;
    f_wdata        = f_rdata;
    case (state)
      ES_IDLE: begin
        if (start) begin
          func_r_next    = req.func;
          key_next       = req.peer_id;
          seq_r_next     = req.seq_value;
          lo_next        = '0;
          hi_next        = SW'(dcount);
          cur_next       = '0;
          pos_r_next     = '0;
          far_phase_next = 1'b0;
          if (req.func == FN_FAR) begin
            status_r_next = (req.peer_id == own_id) ? ST_OWN : ST_FAR_FULL;
          end else begin
            status_r_next = ST_NONE;
          end
        end
      end
      ES_SRCH_CHK, ES_SRCH_CMP: begin
        if (srch_end) begin
          at_next = srch_pos;
          if (far_phase) begin
            if (srch_found) begin
              status_r_next = ST_KNOWN;
              pos_r_next    = srch_pos;
            end else begin
              cur_next = SW'(fcount);
              up_next  = 1'b1;
            end
          end else if (func_r == FN_SENDER) begin
            if (srch_found) begin
              d_we          = 1'b1;
              waddr         = srch_pos;
              d_wid         = key;
              d_wseq        = seq_r;
              status_r_next = ST_UPDATED;
              pos_r_next    = srch_pos;
            end else if (d_full) begin
              status_r_next = ST_FULL;
              pos_r_next    = '0;
            end else begin
              cur_next = SW'(dcount);
              up_next  = 1'b1;
            end
          end else begin
            if (srch_found) begin
              status_r_next = ST_DIRECT;
              pos_r_next    = srch_pos;
            end else begin
              far_phase_next = 1'b1;
              lo_next        = '0;
              hi_next        = SW'(fcount);
            end
          end
        end else if (state == ES_SRCH_CMP) begin
          if (a_lt) begin
            lo_next = mid + SW'(1);
          end else begin
            hi_next = mid;
          end
        end
      end
      ES_AGE_CHK: begin
        if (!age_more) begin
          status_r_next = ST_NONE;
        end
      end
      ES_AGE_CMP: begin
        if (stale) begin
          at_next = cur;
          up_next = 1'b0;
        end else begin
          cur_next = cur_inc[SW-1:0];
        end
      end
      ES_SHIFT_CHK: begin
        if (!shift_more && !up) begin
          dcount_next   = dcount - DCW'(1);
          status_r_next = ST_REMOVED;
          pos_r_next    = at;
        end
      end
      ES_SHIFT_WR: begin
        waddr = cur;
        if (far_phase) begin
          f_we = 1'b1;
        end else begin
          d_we = 1'b1;
        end
        cur_next = up ? (cur - SW'(1)) : cur_inc[SW-1:0];
      end
      ES_NEW_WR: begin
        waddr      = at;
        pos_r_next = at;
        if (far_phase) begin
          f_we          = 1'b1;
          f_wdata       = key;
          fcount_next   = fcount + FCW'(1);
          status_r_next = ST_FAR_ADDED;
        end else begin
          d_we          = 1'b1;
          d_wid         = key;
          d_wseq        = seq_r;
          dcount_next   = dcount + DCW'(1);
          status_r_next = ST_INSERTED;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ES_IDLE;
      dcount <= '0;
      fcount <= '0;
    end else begin
      state  <= state_next;
      dcount <= dcount_next;
      fcount <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_r_next;
    key       <= key_next;
    seq_r     <= seq_r_next;
    lo        <= lo_next;
    hi        <= hi_next;
    cur       <= cur_next;
    at        <= at_next;
    pos_r     <= pos_r_next;
    status_r  <= status_r_next;
    far_phase <= far_phase_next;
    up        <= up_next;
  end

  assign idle               = (state == ES_IDLE);
  assign res_valid          = (state == ES_DONE);
  assign res.status         = status_r;
  assign res.position       = 8'(pos_r);
  assign res.neighbor_total = 6'(dcount);
  assign res.two_hop_total  = 9'(fcount);

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_neighbor_table.sv =====
// Sorted neighbor table: handshake channels, configuration registers, output register.
// Depends on snt_pkg and snt_engine.
//
// Input channel (in_valid/in_ready) takes one request item: func, peer_id,
// seq_value. Output channel (out_valid/out_ready) gives one result item per
// request: status, position, neighbor_total, two_hop_total.
// Configuration: cfg_we writes cfg_data into own_id (index 0) or stale_gap
// (index 1); write only while no request is in flight.
// One request is worked at a time; in_ready is high only while the sequencer
// is idle. Each binary-search probe reads the memory and then compares, and a
// final check closes a search that finds nothing; a two-hop offer searches
// both tables. Every entry moved by an insert or a removal is read and then
// written one place over. Age-out reads and compares each entry up to the
// stale one. An unused func, own id or a full two-hop table goes straight to
// the result; the longest case at the default depths is a two-hop insert at
// the front of a table of 255 entries with a full direct table. The next item
// can be taken the cycle after the result moves to the output register.
// Reset empties both tables (counts to zero), sets own_id 0, stale_gap 100.
// A finished result waits in the output register; while the receiver stalls
// the next request is still taken and worked, and its result holds in the
// sequencer until the output register frees.
`default_nettype none
module sorted_neighbor_table #(
  parameter int DIRECT_DEPTH = 32,
  parameter int FAR_DEPTH    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [15:0] peer_id,
  input  logic [15:0] seq_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [7:0]  position,
  output logic [5:0]  neighbor_total,
  output logic [8:0]  two_hop_total,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import snt_pkg::*;

  logic [15:0] own_id, stale_gap;
  logic        eng_idle, res_valid, res_ack, start;
  req_t        req;
  res_t        res;

  assign req.func      = func;
  assign req.peer_id   = peer_id;
  assign req.seq_value = seq_value;
  assign in_ready      = eng_idle;
  assign start         = in_valid && in_ready;
  assign res_ack       = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id    <= 16'd0;
      stale_gap <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:    own_id <= cfg_data;
        CFG_STALE_GAP: stale_gap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  snt_engine #(
    .DIRECT_DEPTH(DIRECT_DEPTH),
    .FAR_DEPTH   (FAR_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .own_id   (own_id),
    .stale_gap(stale_gap),
    .idle     (eng_idle),
    .res_valid(res_valid),
    .res_ack  (res_ack),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      status         <= res.status;
      position       <= res.position;
      neighbor_total <= res.neighbor_total;
      two_hop_total  <= res.two_hop_total;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("sequencer did not leave idle after an accepted item");

  a_ack_loads_output: assert property (@(posedge clk) disable iff (rst)
    res_ack |=> out_valid)
    else $error("result handed over but output register empty");

  a_no_accept_with_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !in_ready)
    else $error("input ready while a result is pending in the sequencer");

endmodule
`default_nettype wire

// ===== bench/tb_sorted_neighbor_table.sv =====
// Testbench for sorted_neighbor_table: directed rows, then random phases under several
// register settings and handshake idling, checked against an in-bench table model.
// Depends on snt_pkg and the sorted_neighbor_table RTL.
`timescale 1ns / 1ps
module tb_sorted_neighbor_table;
  import snt_pkg::*;

  localparam int DIRECT_DEPTH = 32;
  localparam int FAR_DEPTH    = 256;
  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int WATCHDOG   = 5000;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_WAIT  = 600;
  localparam int NUM_PHASES = 5;
  localparam int FILL_PHASE = 4;

  typedef struct packed {
    logic [1:0]  f;
    logic [15:0] peer;
    logic [15:0] seq;
    logic        typed;
    res_t        want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = FN_SENDER;
  logic [15:0] peer_id = '0;
  logic [15:0] seq_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [7:0]  position;
  logic [5:0]  neighbor_total;
  logic [8:0]  two_hop_total;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_OWN_ID;
  logic [15:0] cfg_data = '0;

  logic [15:0] nb_id [DIRECT_DEPTH];
  logic [15:0] nb_seq [DIRECT_DEPTH];
  logic [15:0] far_id [FAR_DEPTH];
  int          nb_n = 0;
  int          far_n = 0;
  int          far_full_seen = 0;
  logic [15:0] own_cfg = 16'd0;
  logic [15:0] gap_cfg = 16'd100;
  logic [15:0] seq_clock = 16'd0;

  res_t        pending_results[$];
  int          errors = 0;
  int          tx_pct = 0;
  int          rx_pct = 0;
  bit          hold_wanted = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  step_row_t   rows [18];
  logic [15:0] ph_own [NUM_PHASES];
  logic [15:0] ph_gap [NUM_PHASES];
  int          ph_tx [NUM_PHASES];
  int          ph_rx [NUM_PHASES];
  int          ph_len [NUM_PHASES];

  sorted_neighbor_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .peer_id(peer_id), .seq_value(seq_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .position(position),
    .neighbor_total(neighbor_total), .two_hop_total(two_hop_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit lookup(input bit in_far, input logic [15:0] key, output int at);
    int lo;
    int hi;
    int mid;
    logic [15:0] v;
    lo = 0;
    hi = (in_far ? far_n : nb_n) - 1;
    at = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      v = in_far ? far_id[mid] : nb_id[mid];
      if (v == key) begin
        at = mid;
        return 1'b1;
      end
      if (v < key) lo = mid + 1;
      else hi = mid - 1;
    end
    at = lo;
    return 1'b0;
  endfunction

  function automatic res_t apply_request(input logic [1:0] f, input logic [15:0] p,
                                         input logic [15:0] s);
    res_t r;
    int   at;
    int   i;
    int   j;
    int   d;
    bit   done;
    r = '0;
    r.status = ST_NONE;
    at = 0;
    case (f)
      FN_SENDER: begin
        if (lookup(1'b0, p, at)) begin
          nb_seq[at] = s;
          r.status = ST_UPDATED;
          r.position = at[7:0];
        end else if (nb_n >= DIRECT_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = nb_n; i > at; i--) begin
            nb_id[i] = nb_id[i - 1];
            nb_seq[i] = nb_seq[i - 1];
          end
          nb_id[at] = p;
          nb_seq[at] = s;
          nb_n++;
          r.status = ST_INSERTED;
          r.position = at[7:0];
        end
      end
      FN_FAR: begin
        if (p == own_cfg) begin
          r.status = ST_OWN;
        end else if (far_n >= FAR_DEPTH) begin
          r.status = ST_FAR_FULL;
          far_full_seen++;
        end else if (lookup(1'b0, p, at)) begin
          r.status = ST_DIRECT;
          r.position = at[7:0];
        end else if (lookup(1'b1, p, at)) begin
          r.status = ST_KNOWN;
          r.position = at[7:0];
        end else begin
          for (i = far_n; i > at; i--) far_id[i] = far_id[i - 1];
          far_id[at] = p;
          far_n++;
          r.status = ST_FAR_ADDED;
          r.position = at[7:0];
        end
      end
      FN_AGE: begin
        done = 1'b0;
        for (i = 0; i < nb_n && !done; i++) begin
          d = int'(nb_seq[i]) - int'(s);
          if (d < 0) d = -d;
          if (d > int'(gap_cfg)) begin
            for (j = i; j + 1 < nb_n; j++) begin
              nb_id[j] = nb_id[j + 1];
              nb_seq[j] = nb_seq[j + 1];
            end
            nb_n--;
            r.status = ST_REMOVED;
            r.position = i[7:0];
            done = 1'b1;
          end
        end
      end
      default: r.status = ST_NONE;
    endcase
    r.neighbor_total = nb_n[5:0];
    r.two_hop_total = far_n[8:0];
    return r;
  endfunction

  task automatic offer_request(input logic [1:0] f, input logic [15:0] p,
                               input logic [15:0] s, input logic typed, input res_t want);
    res_t got;
    while (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    peer_id <= p;
    seq_value <= s;
    do @(posedge clk); while (!in_ready);
    got = apply_request(f, p, s);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic settle_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic load_config(input logic [15:0] own, input logic [15:0] gap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_ID;
    cfg_data <= own;
    @(posedge clk);
    cfg_index <= CFG_STALE_GAP;
    cfg_data <= gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    own_cfg = own;
    gap_cfg = gap;
  endtask

  task automatic pick_request(input bit fill, output logic [1:0] f, output logic [15:0] p,
                              output logic [15:0] s);
    int r;
    r = $urandom_range(0, 99);
    if (fill) f = r < 10 ? FN_SENDER : r < 92 ? FN_FAR : r < 97 ? FN_AGE : FN_SPARE;
    else f = r < 45 ? FN_SENDER : r < 72 ? FN_FAR : r < 95 ? FN_AGE : FN_SPARE;
    r = $urandom_range(0, 19);
    p = 16'($urandom_range(0, 65535));
    if (r == 0) p = own_cfg;
    else if (r < (fill ? 2 : 5) && nb_n != 0) p = nb_id[$urandom_range(0, nb_n - 1)];
    else if (r < (fill ? 3 : 7) && far_n != 0) p = far_id[$urandom_range(0, far_n - 1)];
    else if (r == 19) p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    seq_clock = seq_clock + 16'($urandom_range(0, 40));
    s = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : seq_clock;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_wanted) begin
      hold_wanted = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_pct != 0 && $urandom_range(0, 99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: status %0d position %0d", status, position);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", 16'(exp_res.status), 16'(status));
        check_field("position", 16'(exp_res.position), 16'(position));
        check_field("neighbor_total", 16'(exp_res.neighbor_total), 16'(neighbor_total));
        check_field("two_hop_total", 16'(exp_res.two_hop_total), 16'(two_hop_total));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          ph;
    int          k;
    logic [1:0]  f;
    logic [15:0] p;
    logic [15:0] s;

    rows[0]  = '{FN_AGE,    16'h0000, 16'h0000, 1'b1, '{ST_NONE,      8'd0, 6'd0, 9'd0}};
    rows[1]  = '{FN_SPARE,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_NONE,      8'd0, 6'd0, 9'd0}};
    rows[2]  = '{FN_FAR,    16'h0000, 16'h0000, 1'b1, '{ST_OWN,       8'd0, 6'd0, 9'd0}};
    rows[3]  = '{FN_SENDER, 16'hFFFF, 16'h0000, 1'b1, '{ST_INSERTED,  8'd0, 6'd1, 9'd0}};
    rows[4]  = '{FN_SENDER, 16'h0000, 16'hFFFF, 1'b1, '{ST_INSERTED,  8'd0, 6'd2, 9'd0}};
    rows[5]  = '{FN_SENDER, 16'hFFFF, 16'h0005, 1'b1, '{ST_UPDATED,   8'd1, 6'd2, 9'd0}};
    rows[6]  = '{FN_FAR,    16'hFFFF, 16'h0000, 1'b1, '{ST_DIRECT,    8'd1, 6'd2, 9'd0}};
    rows[7]  = '{FN_FAR,    16'h1234, 16'h0000, 1'b1, '{ST_FAR_ADDED, 8'd0, 6'd2, 9'd1}};
    rows[8]  = '{FN_FAR,    16'h1234, 16'hFFFF, 1'b1, '{ST_KNOWN,     8'd0, 6'd2, 9'd1}};
    rows[9]  = '{FN_FAR,    16'h0001, 16'h0000, 1'b1, '{ST_FAR_ADDED, 8'd0, 6'd2, 9'd2}};
    rows[10] = '{FN_FAR,    16'h8000, 16'h0000, 1'b0, '0};
    rows[11] = '{FN_SENDER, 16'h5555, 16'h0064, 1'b0, '0};
    // no wrap: seq 0xFFFF against 0 is a gap of 65535
    rows[12] = '{FN_AGE,    16'h0000, 16'h0000, 1'b1, '{ST_REMOVED,   8'd0, 6'd2, 9'd3}};
    rows[13] = '{FN_AGE,    16'hFFFF, 16'h0069, 1'b1, '{ST_NONE,      8'd0, 6'd2, 9'd3}};
    rows[14] = '{FN_AGE,    16'h0000, 16'h006A, 1'b1, '{ST_REMOVED,   8'd1, 6'd1, 9'd3}};
    rows[15] = '{FN_FAR,    16'h5555, 16'h0000, 1'b0, '0};
    rows[16] = '{FN_FAR,    16'h0000, 16'h0000, 1'b1, '{ST_OWN,       8'd0, 6'd1, 9'd3}};
    rows[17] = '{FN_SPARE,  16'h5555, 16'h0000, 1'b1, '{ST_NONE,      8'd0, 6'd1, 9'd3}};

    ph_own = '{16'hFFFF, 16'($urandom_range(0, 65535)), 16'h0000,
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
    ph_gap = '{16'h0000, 16'hFFFF, 16'd20, 16'd200, 16'($urandom_range(0, 300))};
    ph_tx  = '{0, 46, 0, 25, 0};
    ph_rx  = '{0, 0, 46, 25, 0};
    ph_len = '{60, 60, 60, 60, 260};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < 18; k++)
      offer_request(rows[k].f, rows[k].peer, rows[k].seq, rows[k].typed, rows[k].want);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle_all();
      load_config(ph_own[ph], ph_gap[ph]);
      tx_pct = ph_tx[ph];
      rx_pct = ph_rx[ph];
      k = 0;
      while (k < ph_len[ph] ||
             (ph == FILL_PHASE && k < 450 && (far_n < FAR_DEPTH || far_full_seen < 20))) begin
        if (ph == 2 && k == 20) hold_wanted = 1'b1;
        if (ph == 3 && k == 30) settle_all();
        if (ph == FILL_PHASE) begin
          tx_pct = (k % 100 < 50) ? 0 : 46;
          rx_pct = (k % 100 < 25 || k % 100 >= 75) ? 0 : 46;
        end
        pick_request(ph == FILL_PHASE, f, p, s);
        offer_request(f, p, s, 1'b0, '0);
        k++;
      end
    end

    settle_all();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
